[rtl/rpq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rpq_pkg;

	localparam int SLOTS_DEF         = 11;
	localparam int PAYLOAD_BYTES_DEF = 124;

	// Fixed field widths of the item and result channels.
	localparam int DATA_W   = 8;
	localparam int INDEX_W  = 7;
	localparam int LENGTH_W = 7;
	localparam int QUEUED_W = 4;
	localparam int STATUS_W = 2;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_READ   = 2'd1,
		MODE_START  = 2'd2,
		MODE_FINISH = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_NONE     = 2'd0,
		STATUS_ACCEPTED = 2'd1,
		STATUS_REJECTED = 2'd2
	} status_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic exec;
	} cmd_t;

endpackage

`default_nettype wire

[rtl/rpq_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rpq_in_if
	import rpq_pkg::*;
;
	logic               valid;
	logic               ready;
	mode_t              mode;
	logic [DATA_W-1:0]  data_byte;
	logic               last_byte;
	logic [INDEX_W-1:0] byte_index;

	modport source (output valid, mode, data_byte, last_byte, byte_index, input ready);
	modport sink (input valid, mode, data_byte, last_byte, byte_index, output ready);
endinterface

`default_nettype wire

[rtl/rpq_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rpq_out_if
	import rpq_pkg::*;
;
	logic                valid;
	logic                ready;
	status_t             status;
	logic                front_ready;
	logic                busy_res;
	logic [QUEUED_W-1:0] queued;
	logic [LENGTH_W-1:0] front_length;
	logic [DATA_W-1:0]   read_byte;

	modport source (output valid, status, front_ready, busy_res, queued, front_length,
		read_byte, input ready);
	modport sink (input valid, status, front_ready, busy_res, queued, front_length,
		read_byte, output ready);
endinterface

`default_nettype wire

[rtl/rpq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module rpq_ctrl
	import rpq_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire  out_ready,
	output cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;
	assign cmd.exec  = in_valid && in_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q     <= ST_RESP;
						in_ready_q  <= 1'b0;
						out_valid_q <= 1'b1;
					end
				end
				ST_RESP: begin
					if (out_ready) begin
						state_q     <= ST_IDLE;
						in_ready_q  <= 1'b1;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					in_ready_q  <= 1'b1;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/rpq_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module rpq_datapath
	import rpq_pkg::*;
#(
	parameter int SLOTS         = SLOTS_DEF,
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cmd_t                 cmd,
	input  mode_t                mode,
	input  wire [DATA_W-1:0]     data_byte,
	input  wire                  last_byte,
	input  wire [INDEX_W-1:0]    byte_index,
	output status_t              status,
	output logic                 front_ready,
	output logic                 busy_res,
	output logic [QUEUED_W-1:0]  queued,
	output logic [LENGTH_W-1:0]  front_length,
	output logic [DATA_W-1:0]    read_byte
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int FILL_W = $clog2(PAYLOAD_BYTES + 1);
	localparam int DEPTH  = SLOTS * PAYLOAD_BYTES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DATA_W-1:0]   store_mem [DEPTH];
	logic [DATA_W-1:0]   rd_data_q;
	logic                rd_hit_q;
	status_t             status_q;

	logic [LENGTH_W-1:0] slot_len_q [SLOTS];
	logic [SLOT_W-1:0]   head_q;
	logic [SLOT_W-1:0]   tail_q;
	logic [CNT_W-1:0]    count_q;
	logic                in_flight_q;
	logic [FILL_W-1:0]   fill_q;
	logic                overflow_q;

	logic                full;
	logic                too_long;
	logic                overflow_next;
	logic                store_byte;
	logic [FILL_W-1:0]   fill_inc;
	logic                commit;
	logic                ready_now;
	logic [LENGTH_W-1:0] head_len;
	logic                rd_hit;
	logic [SLOT_W-1:0]   head_adv;
	logic [SLOT_W-1:0]   tail_adv;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]   rd_addr;

	assign full          = (count_q == CNT_W'(SLOTS));
	assign too_long      = (fill_q == FILL_W'(PAYLOAD_BYTES));
	assign overflow_next = overflow_q || full || too_long;
	assign store_byte    = !overflow_next;
	assign fill_inc      = fill_q + FILL_W'(store_byte);
	// A stored byte always makes the fill nonzero, so the poison flag alone decides.
	assign commit        = !overflow_next && (fill_inc != '0) && !full;

	assign ready_now = (count_q != '0) && !in_flight_q;
	assign head_len  = slot_len_q[head_q];
	assign rd_hit    = ready_now && (byte_index < head_len)
		&& (32'(byte_index) < PAYLOAD_BYTES);

	assign head_adv = (head_q == SLOT_W'(SLOTS - 1)) ? '0 : head_q + 1'b1;
	assign tail_adv = (tail_q == SLOT_W'(SLOTS - 1)) ? '0 : tail_q + 1'b1;

	// Each slot owns a contiguous run of PAYLOAD_BYTES entries.
	assign wr_addr = ADDR_W'(tail_q) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(fill_q);
	assign rd_addr = ADDR_W'(head_q) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(byte_index);

	always_ff @(posedge clk) begin
		if (cmd.exec && (mode == MODE_PUSH) && store_byte) begin
			store_mem[wr_addr] <= data_byte;
		end
		if (cmd.exec && (mode == MODE_READ) && rd_hit) begin
			rd_data_q <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_len_q[i] <= '0;
			end
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			in_flight_q <= 1'b0;
			fill_q      <= '0;
			overflow_q  <= 1'b0;
			rd_hit_q    <= 1'b0;
			status_q    <= STATUS_NONE;
		end else if (cmd.exec) begin
			rd_hit_q <= 1'b0;
			status_q <= STATUS_NONE;
			case (mode)
				MODE_PUSH: begin
					if (last_byte) begin
						if (commit) begin
							slot_len_q[tail_q] <= LENGTH_W'(fill_inc);
							tail_q             <= tail_adv;
							count_q            <= count_q + 1'b1;
							status_q           <= STATUS_ACCEPTED;
						end else begin
							status_q <= STATUS_REJECTED;
						end
						fill_q     <= '0;
						overflow_q <= 1'b0;
					end else begin
						fill_q     <= fill_inc;
						overflow_q <= overflow_next;
					end
				end
				MODE_READ: begin
					rd_hit_q <= rd_hit;
				end
				MODE_START: begin
					if (count_q != '0) begin
						in_flight_q <= 1'b1;
					end
				end
				MODE_FINISH: begin
					if (in_flight_q && (count_q != '0)) begin
						slot_len_q[head_q] <= '0;
						head_q             <= head_adv;
						count_q            <= count_q - 1'b1;
						in_flight_q        <= 1'b0;
					end
				end
				default: begin
					rd_hit_q <= 1'b0;
				end
			endcase
		end
	end

	// Queue state does not move while a result waits, so these stay stable.
	assign status       = status_q;
	assign front_ready  = ready_now;
	assign busy_res     = in_flight_q;
	assign queued       = QUEUED_W'(count_q);
	assign front_length = ready_now ? head_len : '0;
	assign read_byte    = rd_hit_q ? rd_data_q : '0;

endmodule

`default_nettype wire

[rtl/request_packet_queue.sv]
// Ring queue of variable-length request packets. Each transfer on req is one
// event: a pushed payload byte, a read of one byte of the front packet, a start
// that marks the front in flight, or a finish that retires it. Every event gives
// exactly one result on rsp, in the cycle after it is accepted, carrying the commit
// status, the queue count, the in-flight flag and the front length. The payload
// memory read is registered, and the next event is accepted once the result has
// been transferred. The payload memory needs no clearing after reset; slot
// lengths reset at once.
`timescale 1ns / 1ps
`default_nettype none

module request_packet_queue
	import rpq_pkg::*;
#(
	parameter int SLOTS         = SLOTS_DEF,
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input wire       clk,
	input wire       arst_n,
	rpq_in_if.sink   req,
	rpq_out_if.source rsp
);

	cmd_t cmd;

	rpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	rpq_datapath #(
		.SLOTS         (SLOTS),
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (req.mode),
		.data_byte    (req.data_byte),
		.last_byte    (req.last_byte),
		.byte_index   (req.byte_index),
		.status       (rsp.status),
		.front_ready  (rsp.front_ready),
		.busy_res     (rsp.busy_res),
		.queued       (rsp.queued),
		.front_length (rsp.front_length),
		.read_byte    (rsp.read_byte)
	);

endmodule

`default_nettype wire
